// ----- rtl/arvu_pkg.sv -----
// shared constants, register indexes, controller states and control structs
// for the articlerank vertex update block; no dependencies
package arvu_pkg;

  localparam int DEGREE_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int Q_BITS          = 32;
  localparam int SUM_BITS        = 48;
  // sum is clamped to 2^33 before scaling, so 34 bits carry it
  localparam int CLAMP_BITS      = 34;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 32;
  localparam logic [Q_BITS-1:0] AVG_DEGREE_RESET = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_ITER = 1'b0,
    CFG_AVG_DEGREE = 1'b1
  } cfg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RANK,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic mul;
    logic rank;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic item_last;
    logic deg_zero;
    logic div_last;
  } dp_status_t;

endpackage

// ----- rtl/arvu_if.sv -----
// request channel interfaces for the articlerank vertex update block
// depends on arvu_pkg
interface arvu_in_if import arvu_pkg::*; #(
  parameter int DEGREE_BITS = DEGREE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [Q_BITS-1:0]      edge_value;
  logic                   edge_present;
  logic [DEGREE_BITS-1:0] out_degree;
  logic                   last_of_vertex;

  modport source (output valid, edge_value, edge_present, out_degree, last_of_vertex,
                  input ready);
  modport sink (input valid, edge_value, edge_present, out_degree, last_of_vertex,
                output ready);
endinterface

interface arvu_out_if import arvu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [Q_BITS-1:0] vertex_rank;
  logic [Q_BITS-1:0] edge_share;
  logic              share_valid;

  modport source (output valid, vertex_rank, edge_share, share_valid, input ready);
  modport sink (input valid, vertex_rank, edge_share, share_valid, output ready);
endinterface

// ----- rtl/arvu_ctrl.sv -----
// controller state machine: handshakes, command sequencing for scale, rank and divide
// depends on arvu_pkg
module arvu_ctrl import arvu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.item_last) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        cmd.rank  = 1'b1;
        state_nxt = status.deg_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register valid: set on load, cleared when taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/arvu_dp.sv -----
// datapath: config registers, saturating accumulator, rank scaling,
// restoring divider and output register; depends on arvu_pkg
module arvu_dp import arvu_pkg::*; #(
  parameter int DEGREE_BITS = DEGREE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [Q_BITS-1:0]        in_edge_value,
  input  logic                     in_edge_present,
  input  logic [DEGREE_BITS-1:0]   in_out_degree,
  input  logic                     in_last_of_vertex,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic [Q_BITS-1:0]        out_vertex_rank,
  output logic [Q_BITS-1:0]        out_edge_share,
  output logic                     out_share_valid
);

  localparam int DW = Q_BITS + FRAC_BITS;
  localparam int VW = ((DEGREE_BITS + FRAC_BITS > Q_BITS) ?
                       (DEGREE_BITS + FRAC_BITS) : Q_BITS) + 1;
  localparam int PW = CLAMP_BITS + FRAC_BITS;
  localparam int RW = CLAMP_BITS + 2;
  localparam int CW = $clog2(DW);
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam longint unsigned C015  = (15 * ONE_Q + 50) / 100;
  localparam longint unsigned C085  = (85 * ONE_Q + 50) / 100;
  localparam logic [SUM_BITS-1:0] SUM_MAX   = '1;
  localparam logic [SUM_BITS-1:0] SUM_CLAMP = SUM_BITS'(1) << (CLAMP_BITS - 1);

  logic                   first_r;
  logic [Q_BITS-1:0]      avg_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic                   mode_r;
  logic [DEGREE_BITS-1:0] deg_r;
  logic [CLAMP_BITS-1:0]  s_r;
  logic [PW-1:0]          prod_r;
  logic [VW-1:0]          div_r;
  logic [Q_BITS-1:0]      rank_r;
  logic [DW-1:0]          quo_r;
  logic [VW-1:0]          rem_r;
  logic [CW-1:0]          cnt_r;
  logic [Q_BITS-1:0]      out_rank_r;
  logic [Q_BITS-1:0]      out_share_r;
  logic                   out_sv_r;

  logic [SUM_BITS:0]      sum_add;
  logic [SUM_BITS-1:0]    sum_upd;
  logic [PW:0]            rnd;
  logic [RW-1:0]          rank_w;
  logic [Q_BITS-1:0]      rank_cur;
  logic [VW:0]            trial;
  logic [VW:0]            diff;
  logic                   ge;
  logic [FRAC_BITS-1:0]   c085_w;

  assign c085_w = FRAC_BITS'(C085);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      avg_r   <= AVG_DEGREE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIRST_ITER) begin
        first_r <= cfg_data[0];
      end else begin
        avg_r <= cfg_data[Q_BITS-1:0];
      end
    end
  end

  // saturating accumulation of the accepted edge value
  always_comb begin
    sum_add = {1'b0, sum_r} + (SUM_BITS+1)'(in_edge_value);
    if (!first_r && in_edge_present) begin
      sum_upd = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
    end else begin
      sum_upd = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.accept) begin
      sum_r <= in_last_of_vertex ? '0 : sum_upd;
    end
  end

  // capture the closing item: clamped sum, degree and mode
  always_ff @(posedge clk) begin
    if (cmd.accept && in_last_of_vertex) begin
      s_r    <= (sum_upd >= SUM_CLAMP) ? SUM_CLAMP[CLAMP_BITS-1:0]
                                       : sum_upd[CLAMP_BITS-1:0];
      deg_r  <= in_out_degree;
      mode_r <= first_r;
    end
  end

  // scale by 0.85 and form the divisor
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PW'(s_r) * PW'(c085_w);
      div_r  <= mode_r ? VW'(deg_r) : ((VW'(deg_r) << FRAC_BITS) + VW'(avg_r));
    end
  end

  // round, add 0.15 and saturate; in first-iteration mode the rank is 0.15
  always_comb begin
    rnd    = (PW+1)'(prod_r) + (PW+1)'(ONE_Q >> 1);
    rank_w = RW'(rnd[PW:FRAC_BITS]) + RW'(C015);
    if (mode_r) begin
      rank_cur = Q_BITS'(C015);
    end else if (|rank_w[RW-1:Q_BITS]) begin
      rank_cur = '1;
    end else begin
      rank_cur = rank_w[Q_BITS-1:0];
    end
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.rank) begin
      rank_r <= rank_cur;
      quo_r  <= mode_r ? DW'(ONE_Q) : {rank_cur, FRAC_BITS'(0)};
      rem_r  <= '0;
      cnt_r  <= CW'(DW - 1);
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rank_r <= rank_r;
      out_sv_r   <= !status.deg_zero;
      if (status.deg_zero) begin
        out_share_r <= '0;
      end else if (|quo_r[DW-1:Q_BITS]) begin
        out_share_r <= '1;
      end else begin
        out_share_r <= quo_r[Q_BITS-1:0];
      end
    end
  end

  assign status.item_last = in_last_of_vertex;
  assign status.deg_zero  = (deg_r == '0);
  assign status.div_last  = (cnt_r == '0);

  assign out_vertex_rank = out_rank_r;
  assign out_edge_share  = out_share_r;
  assign out_share_valid = out_sv_r;

endmodule

// ----- rtl/articlerank_vertex_update_top.sv -----
// channel    | dir | payload                                              | handshake
// in_chan    | in  | edge_value, edge_present, out_degree, last_of_vertex | valid/ready
// out_chan   | out | vertex_rank, edge_share, share_valid                 | valid/ready
// cfg_*      | in  | cfg_index, cfg_data                                  | cfg_we
//
// a request without the last mark leaves the input ready; a closing request
// steps through scale, rank and the one-bit-per-cycle restoring divider to
// the output load; with zero out-degree it skips the divider.
// the result sits in an output register, so a stalled output only blocks the
// next closing request at its final step. reset is synchronous, active low.
//
// top level of the articlerank vertex update; depends on arvu_pkg, arvu_if,
// arvu_ctrl and arvu_dp
module articlerank_vertex_update_top import arvu_pkg::*; #(
  parameter int DEGREE_BITS = DEGREE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  arvu_in_if.sink                  in_chan,
  arvu_out_if.source               out_chan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  arvu_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic
  arvu_dp #(
    .DEGREE_BITS (DEGREE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_edge_value     (in_chan.edge_value),
    .in_edge_present   (in_chan.edge_present),
    .in_out_degree     (in_chan.out_degree),
    .in_last_of_vertex (in_chan.last_of_vertex),
    .cmd               (cmd),
    .status            (status),
    .out_vertex_rank   (out_chan.vertex_rank),
    .out_edge_share    (out_chan.edge_share),
    .out_share_valid   (out_chan.share_valid)
  );

`ifndef SYNTH
  // closing request starts the rank computation, input stalls
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.last_of_vertex |=> !in_chan.ready)
    else $error("input still ready after closing request");

  // edge requests never stall the input
  a_edge_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && !in_chan.last_of_vertex |=> in_chan.ready)
    else $error("input stalled after edge request");

  // a new result is loaded while the input is held off
  a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(!in_chan.ready))
    else $error("result loaded while input ready");

  // zero out-degree gives a zero share
  a_zero_share: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.share_valid |-> out_chan.edge_share == '0)
    else $error("share nonzero with zero out-degree");
`endif

endmodule
